@@ rtl/rkn_pkg.sv @@
// ----------------------------------------------------------------------------
// rkn_pkg
// shared types, constants, microcode rom and saturation helper
// ----------------------------------------------------------------------------
package rkn_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int QUO_W  = WORD_W + FRAC_W;
  localparam int CNT_W  = 12;
  localparam int KR2_W  = 31;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [4:0]        reg_t;
  typedef logic [6:0]        pc_t;
  typedef logic [1:0]        code_t;

  localparam code_t ST_OK  = 2'd0;
  localparam code_t ST_HIT = 2'd1;
  localparam code_t ST_SAT = 2'd2;

  localparam word_t ONE_Q = word_t'(1) << FRAC_W;

  localparam reg_t R_Y   = 5'd0;
  localparam reg_t R_YP  = 5'd1;
  localparam reg_t R_X   = 5'd2;
  localparam reg_t R_S   = 5'd3;
  localparam reg_t R_S2  = 5'd4;
  localparam reg_t R_S8  = 5'd5;
  localparam reg_t R_K1  = 5'd6;
  localparam reg_t R_K2  = 5'd7;
  localparam reg_t R_K3  = 5'd8;
  localparam reg_t R_K4  = 5'd9;
  localparam reg_t R_YM  = 5'd10;
  localparam reg_t R_XB  = 5'd11;
  localparam reg_t R_XC  = 5'd12;
  localparam reg_t R_T0  = 5'd13;
  localparam reg_t R_T1  = 5'd14;
  localparam reg_t R_T2  = 5'd15;
  localparam reg_t R_T3  = 5'd16;
  localparam reg_t R_DX  = 5'd17;
  localparam reg_t R_DY  = 5'd18;
  localparam reg_t R_DYP = 5'd19;
  localparam reg_t R_F   = 5'd20;
  localparam reg_t R_KR2 = 5'd21;
  localparam reg_t R_ONE = 5'd22;

  localparam pc_t LOOP_PC = 7'd8;

  typedef enum logic [3:0] {
    OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_HALF, OP_EIGHTH,
    OP_SIXTH, OP_MOV, OP_CHKZ, OP_BRZ, OP_NEXT
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_FIN
  } state_t;

  typedef struct packed {
    op_t  op;
    reg_t rd;
    reg_t ra;
    reg_t rb;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic capture;
    logic rd_en;
    logic exec;
    logic div_start;
    logic publish;
    logic hit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } sat_word_t;

  function automatic sat_word_t sat_from_mag(input logic neg, input logic [QUO_W-1:0] m);
    sat_word_t r;
    logic [QUO_W-1:0] lim;
    lim = {{(QUO_W-WORD_W){1'b0}}, 1'b0, {(WORD_W-1){1'b1}}} + {{(QUO_W-1){1'b0}}, neg};
    if (m > lim) begin
      r.sat = 1'b1;
      r.val = neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      r.sat = 1'b0;
      r.val = neg ? (~m[WORD_W-1:0] + word_t'(1)) : m[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input op_t op, input reg_t rd, input reg_t ra, input reg_t rb);
    uop_t u;
    u.op = op;
    u.rd = rd;
    u.ra = ra;
    u.rb = rb;
    return u;
  endfunction

  // derivative: f = dyp/dx - (kr2 + (1/dx)^2) * dy
  function automatic uop_t deriv_uop(input logic [2:0] k);
    uop_t u;
    unique case (k)
      3'd0: u = mk(OP_DIV, R_T2, R_DYP, R_DX);
      3'd1: u = mk(OP_DIV, R_T3, R_ONE, R_DX);
      3'd2: u = mk(OP_MUL, R_T3, R_T3, R_T3);
      3'd3: u = mk(OP_ADD, R_T3, R_KR2, R_T3);
      3'd4: u = mk(OP_MUL, R_T3, R_T3, R_DY);
      default: u = mk(OP_SUB, R_F, R_T2, R_T3);
    endcase
    return u;
  endfunction

  function automatic uop_t uop_rom(input pc_t pc);
    uop_t u;
    pc_t  off;
    off = '0;
    unique case (pc) inside
      7'd0:  u = mk(OP_LD, R_Y, R_Y, R_Y);
      7'd1:  u = mk(OP_LD, R_YP, R_Y, R_Y);
      7'd2:  u = mk(OP_LD, R_X, R_Y, R_Y);
      7'd3:  u = mk(OP_LD, R_S, R_Y, R_Y);
      7'd4:  u = mk(OP_LD, R_KR2, R_Y, R_Y);
      7'd5:  u = mk(OP_LD, R_ONE, R_Y, R_Y);
      7'd6:  u = mk(OP_HALF, R_S2, R_S, R_S);
      7'd7:  u = mk(OP_EIGHTH, R_S8, R_S, R_S);
      7'd8:  u = mk(OP_BRZ, R_Y, R_Y, R_Y);
      7'd9:  u = mk(OP_CHKZ, R_Y, R_X, R_X);
      7'd10: u = mk(OP_MOV, R_DX, R_X, R_X);
      7'd11: u = mk(OP_MOV, R_DY, R_Y, R_Y);
      7'd12: u = mk(OP_MOV, R_DYP, R_YP, R_YP);
      [7'd13:7'd18]: begin
        off = pc - 7'd13;
        u = deriv_uop(off[2:0]);
      end
      7'd19: u = mk(OP_MUL, R_K1, R_S, R_F);
      7'd20: u = mk(OP_ADD, R_XB, R_X, R_S2);
      7'd21: u = mk(OP_CHKZ, R_Y, R_XB, R_XB);
      7'd22: u = mk(OP_MUL, R_T0, R_S2, R_YP);
      7'd23: u = mk(OP_ADD, R_T0, R_Y, R_T0);
      7'd24: u = mk(OP_MUL, R_T1, R_S8, R_K1);
      7'd25: u = mk(OP_ADD, R_YM, R_T0, R_T1);
      7'd26: u = mk(OP_HALF, R_T0, R_K1, R_K1);
      7'd27: u = mk(OP_ADD, R_DYP, R_YP, R_T0);
      7'd28: u = mk(OP_MOV, R_DX, R_XB, R_XB);
      7'd29: u = mk(OP_MOV, R_DY, R_YM, R_YM);
      [7'd30:7'd35]: begin
        off = pc - 7'd30;
        u = deriv_uop(off[2:0]);
      end
      7'd36: u = mk(OP_MUL, R_K2, R_S, R_F);
      7'd37: u = mk(OP_HALF, R_T0, R_K2, R_K2);
      7'd38: u = mk(OP_ADD, R_DYP, R_YP, R_T0);
      [7'd39:7'd44]: begin
        off = pc - 7'd39;
        u = deriv_uop(off[2:0]);
      end
      7'd45: u = mk(OP_MUL, R_K3, R_S, R_F);
      7'd46: u = mk(OP_ADD, R_XC, R_XB, R_S2);
      7'd47: u = mk(OP_CHKZ, R_Y, R_XC, R_XC);
      7'd48: u = mk(OP_MUL, R_T0, R_S, R_YP);
      7'd49: u = mk(OP_ADD, R_T0, R_Y, R_T0);
      7'd50: u = mk(OP_MUL, R_T1, R_S2, R_K3);
      7'd51: u = mk(OP_ADD, R_DY, R_T0, R_T1);
      7'd52: u = mk(OP_ADD, R_DYP, R_YP, R_K3);
      7'd53: u = mk(OP_MOV, R_DX, R_XC, R_XC);
      [7'd54:7'd59]: begin
        off = pc - 7'd54;
        u = deriv_uop(off[2:0]);
      end
      7'd60: u = mk(OP_MUL, R_K4, R_S, R_F);
      7'd61: u = mk(OP_ADD, R_T0, R_K1, R_K2);
      7'd62: u = mk(OP_ADD, R_T0, R_T0, R_K3);
      7'd63: u = mk(OP_SIXTH, R_T0, R_T0, R_T0);
      7'd64: u = mk(OP_ADD, R_T0, R_YP, R_T0);
      7'd65: u = mk(OP_MUL, R_T0, R_S, R_T0);
      7'd66: u = mk(OP_ADD, R_Y, R_Y, R_T0);
      7'd67: u = mk(OP_ADD, R_T0, R_K1, R_K2);
      7'd68: u = mk(OP_ADD, R_T0, R_T0, R_K2);
      7'd69: u = mk(OP_ADD, R_T0, R_T0, R_K3);
      7'd70: u = mk(OP_ADD, R_T0, R_T0, R_K3);
      7'd71: u = mk(OP_ADD, R_T0, R_T0, R_K4);
      7'd72: u = mk(OP_SIXTH, R_T0, R_T0, R_T0);
      7'd73: u = mk(OP_ADD, R_YP, R_YP, R_T0);
      7'd74: u = mk(OP_MOV, R_X, R_XC, R_XC);
      default: u = mk(OP_NEXT, R_Y, R_Y, R_Y);
    endcase
    return u;
  endfunction

endpackage

@@ rtl/bessel_ode_rkn4_stepper.sv @@
// ----------------------------------------------------------------------------
// bessel_ode_rkn4_stepper
// fourth-order runge-kutta-nystrom stepper for w'' = w'/x - (kr2 + 1/x^2) w
// ----------------------------------------------------------------------------
// channel  direction  beat contents
// s_*      in         w_start, dw_start, x_start, step_size, step_count
// m_*      out        w_end, dw_end, x_end, status
// cfg_*    in         wave_number_squared
//
// a step runs 58 alu micro-ops, each a read then an execute, eight divides in the
// shared serial divider, plus loop test and jump; a beat adds load and publish,
// and x reaching zero stops early
// one beat is worked at a time; the next input is taken once the result
// sits in the output register, and the result waits there while m_tready is low
// rst is synchronous and returns wave_number_squared to 1.0
// ----------------------------------------------------------------------------
module bessel_ode_rkn4_stepper
  import rkn_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [143:0]  s_tdata,   // w_start, dw_start, x_start, step_size, step_count
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // w_end, dw_end, x_end, status
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [30:0]   cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  word_t      w_end;
  word_t      dw_end;
  word_t      x_end;
  code_t      status_code;

  assign cfg_ready = 1'b1;

  rkn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .step_count (s_tdata[139:128]),
    .status     (status),
    .cmd        (cmd)
  );

  rkn_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .w_start     (s_tdata[31:0]),
    .dw_start    (s_tdata[63:32]),
    .x_start     (s_tdata[95:64]),
    .step_size   (s_tdata[127:96]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .w_end       (w_end),
    .dw_end      (dw_end),
    .x_end       (x_end),
    .status_code (status_code)
  );

  assign m_tdata = {6'b0, status_code, x_end, dw_end, w_end};

endmodule

@@ rtl/rkn_div.sv @@
// ----------------------------------------------------------------------------
// rkn_div
// restoring divider, one quotient bit per cycle, saturating q16.16 result
// ----------------------------------------------------------------------------
module rkn_div
  import rkn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t a,
  input  word_t b,
  output logic  done,
  output word_t q,
  output logic  q_sat
);

  logic             busy;
  logic [5:0]       cnt;
  logic [QUO_W-1:0] num;
  word_t            rem;
  word_t            den;
  logic             neg;
  word_t            ma;
  word_t            mb;
  logic [WORD_W:0]  rem_sh;
  logic [WORD_W:0]  diff;
  logic             ge;
  sat_word_t        res;

  assign ma     = a[WORD_W-1] ? (~a + word_t'(1)) : a;
  assign mb     = b[WORD_W-1] ? (~b + word_t'(1)) : b;
  assign rem_sh = {rem, num[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign diff   = rem_sh - {1'b0, den};
  assign res    = sat_from_mag(neg, num);
  assign q      = res.val;
  assign q_sat  = res.sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= {ma, {FRAC_W{1'b0}}};
      den <= mb;
      rem <= '0;
      neg <= a[WORD_W-1] ^ b[WORD_W-1];
    end else if (busy) begin
      rem <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      num <= {num[QUO_W-2:0], ge};
    end
  end

endmodule

@@ rtl/rkn_dp.sv @@
// ----------------------------------------------------------------------------
// rkn_dp
// datapath: register memory, saturating alu, divider and result register
// ----------------------------------------------------------------------------
module rkn_dp
  import rkn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  word_t                w_start,
  input  word_t                dw_start,
  input  word_t                x_start,
  input  word_t                step_size,
  input  logic                 cfg_valid,
  input  logic [KR2_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output word_t                w_end,
  output word_t                dw_end,
  output word_t                x_end,
  output code_t                status_code
);

  word_t              mem [32];
  word_t              ra_q;
  word_t              rb_q;
  word_t              w_hold;
  word_t              dw_hold;
  word_t              x_hold;
  word_t              s_hold;
  logic [KR2_W-1:0]   kr2;
  word_t              y_sh;
  word_t              yp_sh;
  word_t              x_sh;
  logic               sat_flag;

  word_t              ma;
  word_t              mb;
  logic [WORD_W:0]    sum33;
  logic [WORD_W:0]    dif33;
  logic [2*WORD_W-1:0] prod;
  logic [2*WORD_W-1:0] p6;
  word_t              q6;
  word_t              h;
  word_t              e;
  sat_word_t          mul_r;
  word_t              res;
  logic               res_sat;
  logic               div_done;
  word_t              div_q;
  logic               div_sat;
  logic               wr_en;
  word_t              wr_val;
  logic               wr_sat;

  rkn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .a     (ra_q),
    .b     (rb_q),
    .done  (div_done),
    .q     (div_q),
    .q_sat (div_sat)
  );

  assign ma    = ra_q[WORD_W-1] ? (~ra_q + word_t'(1)) : ra_q;
  assign mb    = rb_q[WORD_W-1] ? (~rb_q + word_t'(1)) : rb_q;
  assign sum33 = {ra_q[WORD_W-1], ra_q} + {rb_q[WORD_W-1], rb_q};
  assign dif33 = {ra_q[WORD_W-1], ra_q} - {rb_q[WORD_W-1], rb_q};
  assign prod  = ma * mb;
  assign mul_r = sat_from_mag(ra_q[WORD_W-1] ^ rb_q[WORD_W-1], prod[2*WORD_W-1:FRAC_W]);
  // divide by six as multiply by 2^34 / 6, the scaled reciprocal, then shift right by 34
  assign p6    = ma * 32'hAAAA_AAAB;
  assign q6    = {2'b00, p6[2*WORD_W-1:34]};
  assign h     = ra_q + {{(WORD_W-1){1'b0}}, ra_q[WORD_W-1]};
  assign e     = ra_q + {{(WORD_W-3){1'b0}}, {3{ra_q[WORD_W-1]}}};

  always_comb begin
    res     = ra_q;
    res_sat = 1'b0;
    case (cmd.uop.op)
      OP_LD: begin
        case (cmd.uop.rd)
          R_Y:     res = w_hold;
          R_YP:    res = dw_hold;
          R_X:     res = x_hold;
          R_S:     res = s_hold;
          R_KR2:   res = {1'b0, kr2};
          default: res = ONE_Q;
        endcase
      end
      OP_ADD: begin
        res_sat = sum33[WORD_W] ^ sum33[WORD_W-1];
        res = res_sat ? {sum33[WORD_W], {(WORD_W-1){~sum33[WORD_W]}}} : sum33[WORD_W-1:0];
      end
      OP_SUB: begin
        res_sat = dif33[WORD_W] ^ dif33[WORD_W-1];
        res = res_sat ? {dif33[WORD_W], {(WORD_W-1){~dif33[WORD_W]}}} : dif33[WORD_W-1:0];
      end
      OP_MUL: begin
        res     = mul_r.val;
        res_sat = mul_r.sat;
      end
      OP_HALF:   res = {h[WORD_W-1], h[WORD_W-1:1]};
      OP_EIGHTH: res = {{3{e[WORD_W-1]}}, e[WORD_W-1:3]};
      OP_SIXTH:  res = ra_q[WORD_W-1] ? (~q6 + word_t'(1)) : q6;
      default:   res = ra_q;
    endcase
  end

  assign wr_en  = cmd.exec | div_done;
  assign wr_val = div_done ? div_q : res;
  assign wr_sat = div_done ? div_sat : res_sat;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.uop.rd] <= wr_val;
    end
    if (cmd.rd_en) begin
      ra_q <= mem[cmd.uop.ra];
      rb_q <= mem[cmd.uop.rb];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w_hold  <= w_start;
      dw_hold <= dw_start;
      x_hold  <= x_start;
      s_hold  <= step_size;
    end
    if (wr_en && cmd.uop.rd == R_Y) begin
      y_sh <= wr_val;
    end
    if (wr_en && cmd.uop.rd == R_YP) begin
      yp_sh <= wr_val;
    end
    if (wr_en && cmd.uop.rd == R_X) begin
      x_sh <= wr_val;
    end
    if (cmd.publish) begin
      w_end       <= y_sh;
      dw_end      <= yp_sh;
      x_end       <= x_sh;
      status_code <= cmd.hit ? ST_HIT : (sat_flag ? ST_SAT : ST_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kr2       <= KR2_W'(65536);
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        kr2 <= cfg_data;
      end
      if (cmd.capture) begin
        sat_flag <= 1'b0;
      end else if (wr_en && wr_sat) begin
        sat_flag <= 1'b1;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.a_zero   = ra_q == '0;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ rtl/rkn_ctrl.sv @@
// ----------------------------------------------------------------------------
// rkn_ctrl
// microcode sequencer: program counter, step counter and state machine
// ----------------------------------------------------------------------------
module rkn_ctrl
  import rkn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CNT_W-1:0]  step_count,
  input  dp_status_t        status,
  output ctrl_cmd_t         cmd
);

  state_t             state;
  state_t             state_next;
  pc_t                pc;
  logic [CNT_W-1:0]   count;
  logic               hit;
  uop_t               uop;
  logic               writes;

  assign uop = uop_rom(pc);

  always_comb begin
    case (uop.op) inside
      OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_HALF, OP_EIGHTH, OP_SIXTH, OP_MOV: writes = 1'b1;
      default: writes = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        if (uop.op == OP_BRZ) begin
          if (count == '0) state_next = ST_FIN;
        end else if (uop.op != OP_NEXT) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (uop.op == OP_DIV) state_next = ST_DIV;
        else if (uop.op == OP_CHKZ && status.a_zero) state_next = ST_FIN;
        else state_next = ST_READ;
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_READ;
      end
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = state == ST_IDLE;
    cmd.uop       = uop;
    cmd.capture   = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.exec      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.publish   = 1'b0;
    cmd.hit       = hit;
    unique case (state)
      ST_IDLE: cmd.capture = in_valid;
      ST_READ: cmd.rd_en = 1'b1;
      ST_EXEC: begin
        cmd.exec      = writes;
        cmd.div_start = uop.op == OP_DIV;
      end
      ST_DIV:  cmd.exec = 1'b0;
      ST_FIN:  cmd.publish = status.out_free;
      default: cmd.exec = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      count <= '0;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            pc    <= '0;
            count <= step_count;
            hit   <= 1'b0;
          end
        end
        ST_READ: begin
          if (uop.op == OP_NEXT) begin
            pc    <= LOOP_PC;
            count <= count - CNT_W'(1);
          end else if (uop.op == OP_BRZ) begin
            if (count != '0) pc <= pc + 7'd1;
          end
        end
        ST_EXEC: begin
          if (uop.op == OP_CHKZ && status.a_zero) begin
            hit <= 1'b1;
          end else if (uop.op != OP_DIV) begin
            pc <= pc + 7'd1;
          end
        end
        ST_DIV: begin
          if (status.div_done) pc <= pc + 7'd1;
        end
        default: pc <= pc;
      endcase
    end
  end

endmodule
